@@ rtl/stid_pkg.sv @@
// ----------------------------------------------------------------------------
// stid_pkg
// Shared types and constants of the sorted table insert/delete unit.
// ----------------------------------------------------------------------------
package stid_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int VALUE_W      = 32;
   localparam int OP_W         = 2;
   localparam int RANK_W       = 6;
   localparam int STATUS_W     = 3;
   localparam int COUNT_OUT_W  = 7;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_READ      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_CMP,
      S_INS_PUT,
      S_DEL_SCAN,
      S_DEL_SHIFT,
      S_RD_WAIT,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic signed [VALUE_W-1:0] value;
      logic [RANK_W-1:0]         rank;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] read_value;
      logic [COUNT_OUT_W-1:0]    entry_count;
   } rsp_type;

endpackage

@@ rtl/stid_if.sv @@
// ----------------------------------------------------------------------------
// stid_req_if / stid_rsp_if
// Valid/ready channels carrying request and response beats.
// ----------------------------------------------------------------------------
interface stid_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [stid_pkg::OP_W-1:0]              operation;
   logic signed [stid_pkg::VALUE_W-1:0]    value;
   logic [stid_pkg::RANK_W-1:0]            rank;

   modport source (output valid, output operation, output value, output rank, input ready);
   modport sink   (input valid, input operation, input value, input rank, output ready);
endinterface

interface stid_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [stid_pkg::STATUS_W-1:0]          status;
   logic signed [stid_pkg::VALUE_W-1:0]    read_value;
   logic [stid_pkg::COUNT_OUT_W-1:0]       entry_count;

   modport source (output valid, output status, output read_value, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input entry_count,
                   output ready);
endinterface

@@ rtl/stid_ram.sv @@
// ----------------------------------------------------------------------------
// stid_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module stid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/stid_core.sv @@
// ----------------------------------------------------------------------------
// stid_core
// Sequencer and shared compare unit; walks the table one entry per cycle
// to search and shift, using the value RAM.
// ----------------------------------------------------------------------------
module stid_core #(
   parameter int CAPACITY = stid_pkg::CAPACITY_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  stid_pkg::req_type req_beat,
   output logic              res_valid,
   input  logic              res_ready,
   output stid_pkg::rsp_type res_beat
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int RW = (CW > stid_pkg::RANK_W) ? CW : stid_pkg::RANK_W;
   localparam logic [CW-1:0] CAP_W = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_W = CW'(1);
   localparam logic [CW-1:0] TWO_W = CW'(2);

   stid_pkg::state_type  state_ff, state_in;
   stid_pkg::status_type status_ff, status_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     idx_ff, idx_in;
   logic signed [stid_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [stid_pkg::VALUE_W-1:0]      rdval_ff, rdval_in;

   logic                              ram_wr_en, ram_rd_en;
   logic [AW-1:0]                     ram_wr_addr, ram_rd_addr;
   logic [stid_pkg::VALUE_W-1:0]      ram_wr_data, ram_rd_data;

   logic                              accept;
   logic                              is_insert, is_delete;
   logic                              cmp_less, cmp_eq, more;
   logic [CW-1:0]                     idx_dec, idx_dec2, idx_inc, count_dec;
   logic [RW-1:0]                     rank_ext, count_ext;
   logic                              rank_ok;
   logic [CW+stid_pkg::COUNT_OUT_W-1:0] count_out_ext;

   stid_ram #(
      .WIDTH (stid_pkg::VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready = (state_ff == stid_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_insert = (req_beat.operation == stid_pkg::OP_INSERT);
   assign is_delete = (req_beat.operation == stid_pkg::OP_DELETE);

   // shared compare unit against the entry just read
   assign cmp_less  = value_ff < $signed(ram_rd_data);
   assign cmp_eq    = (value_ff == $signed(ram_rd_data));
   assign idx_dec   = idx_ff - ONE_W;
   assign idx_dec2  = idx_ff - TWO_W;
   assign idx_inc   = idx_ff + ONE_W;
   assign count_dec = count_ff - ONE_W;
   assign more      = (idx_inc < count_ff);

   assign rank_ext  = RW'(req_beat.rank);
   assign count_ext = RW'(count_ff);
   assign rank_ok   = (rank_ext < count_ext);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stid_pkg::S_IDLE: begin
            if (accept) begin
               if (is_insert) begin
                  if (count_ff >= CAP_W) begin
                     state_in = stid_pkg::S_FIN;
                  end else if (count_ff == '0) begin
                     state_in = stid_pkg::S_INS_PUT;
                  end else begin
                     state_in = stid_pkg::S_INS_CMP;
                  end
               end else if (is_delete) begin
                  state_in = (count_ff == '0) ? stid_pkg::S_FIN : stid_pkg::S_DEL_SCAN;
               end else begin
                  state_in = rank_ok ? stid_pkg::S_RD_WAIT : stid_pkg::S_FIN;
               end
            end
         end
         stid_pkg::S_INS_CMP: begin
            if (!cmp_less) begin
               state_in = stid_pkg::S_FIN;
            end else if (idx_dec == '0) begin
               state_in = stid_pkg::S_INS_PUT;
            end
         end
         stid_pkg::S_INS_PUT: state_in = stid_pkg::S_FIN;
         stid_pkg::S_DEL_SCAN: begin
            if (cmp_eq) begin
               state_in = more ? stid_pkg::S_DEL_SHIFT : stid_pkg::S_FIN;
            end else if (!more) begin
               state_in = stid_pkg::S_FIN;
            end
         end
         stid_pkg::S_DEL_SHIFT: begin
            if (!more) begin
               state_in = stid_pkg::S_FIN;
            end
         end
         stid_pkg::S_RD_WAIT: state_in = stid_pkg::S_FIN;
         stid_pkg::S_FIN: begin
            if (res_ready) begin
               state_in = stid_pkg::S_IDLE;
            end
         end
         default: state_in = stid_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[AW-1:0];
      ram_wr_data = value_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_dec[AW-1:0];
      count_in    = count_ff;
      idx_in      = idx_ff;
      value_in    = value_ff;
      status_in   = status_ff;
      rdval_in    = rdval_ff;
      res_valid   = 1'b0;
      case (state_ff)
         stid_pkg::S_IDLE: begin
            if (accept) begin
               value_in = req_beat.value;
               rdval_in = '0;
               if (is_insert) begin
                  idx_in    = count_ff;
                  status_in = (count_ff >= CAP_W) ? stid_pkg::ST_FULL : stid_pkg::ST_INSERTED;
                  // start the walk at the last stored entry
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = count_dec[AW-1:0];
               end else if (is_delete) begin
                  idx_in      = '0;
                  status_in   = stid_pkg::ST_NOT_FOUND;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
               end else begin
                  status_in   = stid_pkg::ST_READ;
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rank_ext[AW-1:0];
               end
            end
         end
         stid_pkg::S_INS_CMP: begin
            // entry idx-1 is on the read port; move it up or drop the value in
            ram_wr_en = 1'b1;
            if (cmp_less) begin
               ram_wr_data = ram_rd_data;
               idx_in      = idx_dec;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_dec2[AW-1:0];
            end else begin
               count_in = count_ff + ONE_W;
            end
         end
         stid_pkg::S_INS_PUT: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + ONE_W;
         end
         stid_pkg::S_DEL_SCAN: begin
            if (cmp_eq) begin
               status_in = stid_pkg::ST_DELETED;
               if (!more) begin
                  count_in = count_ff - ONE_W;
               end
            end
            if (more) begin
               idx_in      = idx_inc;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc[AW-1:0];
            end
         end
         stid_pkg::S_DEL_SHIFT: begin
            // pull entry idx down one place
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_dec[AW-1:0];
            ram_wr_data = ram_rd_data;
            if (more) begin
               idx_in      = idx_inc;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc[AW-1:0];
            end else begin
               count_in = count_ff - ONE_W;
            end
         end
         stid_pkg::S_RD_WAIT: begin
            rdval_in = ram_rd_data;
         end
         stid_pkg::S_FIN: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stid_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   assign count_out_ext        = {{stid_pkg::COUNT_OUT_W{1'b0}}, count_ff};
   assign res_beat.status      = status_ff;
   assign res_beat.read_value  = rdval_ff;
   assign res_beat.entry_count = count_out_ext[stid_pkg::COUNT_OUT_W-1:0];

endmodule

@@ rtl/sorted_table_insert_delete_unit.sv @@
// Sequencing: a full insert, an empty delete or an out-of-range read goes from
//   idle straight to the finish state, a read through the read-wait state; an
//   insert or delete may walk the whole table before the finish state.
// Throughput: one operation at a time, next request taken the cycle after the
//   response is registered; the table walk advances one entry per cycle
//   through the single RAM read port and one shared comparator.
// Reset: clears the entry count and the sequencer; table contents stay
//   undefined, no clearing pass.
// ----------------------------------------------------------------------------
// sorted_table_insert_delete_unit
// Ordered table of signed values with insert, delete and rank read.
// ----------------------------------------------------------------------------
module sorted_table_insert_delete_unit #(
   parameter int CAPACITY = stid_pkg::CAPACITY_DEF
) (
   input  logic      clock,
   input  logic      reset,
   stid_req_if.sink   req_chan,
   stid_rsp_if.source rsp_chan
);

   stid_pkg::req_type req_beat;
   stid_pkg::rsp_type res_beat;
   stid_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              res_valid, res_ready;
   logic              core_ready;

   assign req_beat.operation = req_chan.operation;
   assign req_beat.value     = req_chan.value;
   assign req_beat.rank      = req_chan.rank;
   assign req_chan.ready     = core_ready;

   stid_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (core_ready),
      .req_beat  (req_beat),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_beat  (res_beat)
   );

   // output register: takes a new beat when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_data_in  = res_beat;
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_data_ff.status;
   assign rsp_chan.read_value  = rsp_data_ff.read_value;
   assign rsp_chan.entry_count = rsp_data_ff.entry_count;

endmodule

@@ dv/tb_sorted_table_insert_delete_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_delete_unit
// Self-checking bench for the sorted table: directed corner cases, fill to
// full, back-pressure and random insert/delete/read traffic, all checked
// beat by beat against an in-bench model of the ordered table.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_delete_unit;
   import stid_pkg::*;

   localparam int TABLE_DEPTH   = CAPACITY_DEF;
   localparam int IDLE_LIMIT    = 5000;
   localparam int HOLD_SPAN     = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int MAX_GAP       = 40;
   localparam int REPORT_LIMIT  = 10;

   // code three is not named in the package; the block decodes it as a read
   localparam logic [OP_W-1:0] OP_READ_ALIAS = 2'd3;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic clock = 1'b0;
   logic reset;

   always #10 clock = ~clock;

   stid_req_if req_chan ();
   stid_rsp_if rsp_chan ();

   sorted_table_insert_delete_unit #(
      .CAPACITY (TABLE_DEPTH)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // model of the table contents and occupancy
   logic signed [VALUE_W-1:0] model_vals [TABLE_DEPTH];
   int                        model_count = 0;

   rsp_type pending_rsp_q [$];

   int req_idle_pct   = 0;
   int rsp_idle_pct   = 0;
   int rsp_hold_ask   = 0;
   int rsp_hold_left  = 0;
   int idle_cycles    = 0;
   int mismatch_count = 0;

   // ------------------------------------------------------------------------
   // Model: applies one operation to the table, returns the response beat.
   // ------------------------------------------------------------------------
   function automatic rsp_type model_table_op(input logic [OP_W-1:0] op,
                                              input logic signed [VALUE_W-1:0] v,
                                              input logic [RANK_W-1:0] rank);
      rsp_type r;
      int      pos;
      int      i;
      r.status     = ST_READ;
      r.read_value = '0;
      pos          = 0;
      case (op)
         OP_INSERT: begin
            if (model_count >= TABLE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // lands after any equal values
               while (pos < model_count && !(v < model_vals[pos])) pos++;
               for (i = model_count; i > pos; i--) model_vals[i] = model_vals[i-1];
               model_vals[pos] = v;
               model_count++;
               r.status = ST_INSERTED;
            end
         end
         OP_DELETE: begin
            while (pos < model_count && model_vals[pos] !== v) pos++;
            if (pos >= model_count) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (i = pos; i + 1 < model_count; i++) model_vals[i] = model_vals[i+1];
               model_count--;
               r.status = ST_DELETED;
            end
         end
         default: begin
            if (int'(rank) < model_count) r.read_value = model_vals[rank];
         end
      endcase
      r.entry_count = COUNT_OUT_W'(model_count);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_op(input logic [OP_W-1:0] op,
                          input logic signed [VALUE_W-1:0] v,
                          input logic [RANK_W-1:0] rank);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.value     <= v;
      req_chan.rank      <= rank;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_rsp_q.push_back(model_table_op(op, v, rank));
   endtask

   // drop valid and wait for every outstanding response
   task automatic hold_sender_until_drained();
      req_chan.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       return VAL_MIN;
               1:       return VAL_MAX;
               2:       return '0;
               default: return -1;
            endcase
         end
         1, 2, 3: return $signed($urandom_range(16)) - 8;   // dense range, many duplicates
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_stored();
      if (model_count == 0) return pick_value();
      return model_vals[$urandom_range(model_count - 1)];
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      if (model_count > 0 && $urandom_range(9) < 7)
         return RANK_W'($urandom_range(model_count - 1));
      return RANK_W'($urandom_range(2**RANK_W - 1));
   endfunction

   task automatic send_random_op(input int insert_pct);
      int r;
      r = $urandom_range(99);
      if (r < 20) begin
         send_op(($urandom_range(4) == 0) ? OP_READ_ALIAS : OP_READ, pick_value(), pick_rank());
      end else if (r - 20 < insert_pct * 80 / 100) begin
         send_op(OP_INSERT, pick_value(), RANK_W'($urandom));
      end else begin
         send_op(OP_DELETE, ($urandom_range(9) < 8) ? pick_stored() : pick_value(),
                 RANK_W'($urandom));
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed();
      send_op(OP_DELETE, '0, '0);              // empty table: not found
      send_op(OP_READ, '0, '0);                // empty table: rank invalid
      send_op(OP_READ, VAL_MAX, '1);
      send_op(OP_INSERT, VAL_MAX, '0);
      send_op(OP_INSERT, VAL_MIN, '1);
      send_op(OP_INSERT, '0, '0);
      send_op(OP_INSERT, -1, '0);
      send_op(OP_INSERT, '0, '0);              // duplicate
      send_op(OP_INSERT, VAL_MAX, '0);         // duplicate at the top
      send_op(OP_READ, '0, 6'd0);
      send_op(OP_READ, '0, 6'd1);
      send_op(OP_READ, '0, 6'd2);
      send_op(OP_READ, '0, 6'd3);
      send_op(OP_READ, '0, 6'd5);
      send_op(OP_READ, '0, 6'd6);              // one past the last entry
      send_op(OP_READ, '1, '1);
      send_op(OP_READ_ALIAS, VAL_MIN, 6'd4);
      send_op(OP_DELETE, '0, '0);              // removes one of two equal values
      send_op(OP_DELETE, 32'sd5, '0);          // absent
      send_op(OP_DELETE, VAL_MIN, '1);
      send_op(OP_DELETE, VAL_MAX, '0);
      send_op(OP_READ, '0, 6'd0);
      send_op(OP_READ_ALIAS, '0, 6'd3);
   endtask

   task automatic test_fill_to_full();
      while (model_count < TABLE_DEPTH) send_op(OP_INSERT, pick_value(), RANK_W'($urandom));
      send_op(OP_INSERT, VAL_MIN, '0);         // full: no change
      send_op(OP_INSERT, VAL_MAX, '0);
      send_op(OP_READ, '0, '1);                // last rank is valid when full
      send_op(OP_READ, '0, '0);
      send_op(OP_DELETE, pick_stored(), '0);
      send_op(OP_INSERT, VAL_MAX, '0);
      send_op(OP_INSERT, pick_value(), '0);
      send_op(OP_READ_ALIAS, '0, '1);
   endtask

   // receiver stalls long while the sender keeps offering beats
   task automatic test_backpressure();
      rsp_hold_ask = HOLD_SPAN;
      repeat (16) send_random_op(50);
      hold_sender_until_drained();
   endtask

   task automatic test_random_mix(input int n);
      int k;
      for (k = 0; k < n; k++) send_random_op(((k / 60) % 2 == 0) ? 75 : 25);
   endtask

   task automatic test_drain_to_empty();
      while (model_count > 0) send_op(OP_DELETE, pick_stored(), RANK_W'($urandom));
      send_op(OP_DELETE, pick_value(), '0);
      send_op(OP_READ, '0, '0);
   endtask

   // ------------------------------------------------------------------------
   // Receiver ready, response check, watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (rsp_hold_ask > 0) begin
         rsp_hold_left = rsp_hold_ask;
         rsp_hold_ask  = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("%0t: unexpected rsp beat status %0d value %0d count %0d", $realtime,
                        rsp_chan.status, rsp_chan.read_value, rsp_chan.entry_count);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_chan.status !== want.status || rsp_chan.read_value !== want.read_value ||
                rsp_chan.entry_count !== want.entry_count) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: rsp mismatch exp status %0d value %0d count %0d, got %0d %0d %0d",
                           $realtime, want.status, want.read_value, want.entry_count,
                           rsp_chan.status, rsp_chan.read_value, rsp_chan.entry_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("sorted_table_insert_delete_unit regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.operation <= OP_INSERT;
      req_chan.value     <= '0;
      req_chan.rank      <= '0;
      req_idle_pct        = 14;
      rsp_idle_pct        = 87;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_fill_to_full();
      test_backpressure();
      test_random_mix(250);

      req_idle_pct = 87;
      rsp_idle_pct = 14;
      test_random_mix(250);
      test_drain_to_empty();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random_mix(250);

      hold_sender_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
         $display("sorted_table_insert_delete_unit regression: pass");
      end else begin
         $display("sorted_table_insert_delete_unit regression: fail");
      end
      $finish;
   end

endmodule
